>>> rtl/core/ite_pkg.sv
package ite_pkg;

  localparam int TW = 32;
  localparam int EW = 2 * TW;

  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_APPEND = 3'd1;
  localparam logic [2:0] CMD_SPLIT  = 3'd2;
  localparam logic [2:0] CMD_TRIM_L = 3'd3;
  localparam logic [2:0] CMD_TRIM_R = 3'd4;
  localparam logic [2:0] CMD_READ   = 3'd5;

  typedef struct packed {
    logic          found;
    logic [TW-1:0] s;
    logic [TW-1:0] e;
  } hit_t;

  typedef struct packed {
    logic clr;
    logic en;
  } scan_ctl_t;

endpackage

>>> rtl/core/ite_if.sv
interface ite_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [31:0] time_point;
  logic [31:0] time_end;
  logic [3:0]  entry_index;

  modport source (output valid, cmd, time_point, time_end, entry_index, input ready);
  modport sink (input valid, cmd, time_point, time_end, entry_index, output ready);
endinterface

interface ite_out_if #(parameter int CW = 5);
  logic          valid;
  logic          ready;
  logic [CW-1:0] entry_count;
  logic [31:0]   read_start;
  logic [31:0]   read_end;
  logic          table_changed;
  logic          overflow;

  modport source (output valid, entry_count, read_start, read_end, table_changed, overflow,
                  input ready);
  modport sink (input valid, entry_count, read_start, read_end, table_changed, overflow,
                output ready);
endinterface

>>> rtl/core/ite_ram.sv
module ite_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/ite_scan.sv
module ite_scan import ite_pkg::*; #(
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  scan_ctl_t     ctl,
  input  logic [AW-1:0] idx,
  input  logic [EW-1:0] entry,
  input  logic [TW-1:0] t,
  output hit_t          before_o,
  output hit_t          after_o,
  output logic [AW-1:0] b_idx_o,
  output logic [AW-1:0] a_idx_o
);

  hit_t          bh_r, bh_nxt, ah_r, ah_nxt;
  logic [AW-1:0] bi_r, bi_nxt, ai_r, ai_nxt;
  logic [TW-1:0] s, e;
  logic          b_take, a_take;

  assign s = entry[EW-1:TW];
  assign e = entry[TW-1:0];

  // ascending scan with strict compares keeps the lowest index on ties
  assign b_take = (s <= t) && (!bh_r.found || (e > bh_r.e));
  assign a_take = (e > t) && (!ah_r.found || (s < ah_r.s));

  always_comb begin
    bh_nxt = bh_r;
    ah_nxt = ah_r;
    bi_nxt = bi_r;
    ai_nxt = ai_r;
    if (ctl.clr) begin
      bh_nxt.found = 1'b0;
      ah_nxt.found = 1'b0;
    end else if (ctl.en) begin
      if (b_take) begin
        bh_nxt = '{found: 1'b1, s: s, e: e};
        bi_nxt = idx;
      end
      if (a_take) begin
        ah_nxt = '{found: 1'b1, s: s, e: e};
        ai_nxt = idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bh_r.found <= 1'b0;
      ah_r.found <= 1'b0;
    end else begin
      bh_r.found <= bh_nxt.found;
      ah_r.found <= ah_nxt.found;
    end
    bh_r.s <= bh_nxt.s;
    bh_r.e <= bh_nxt.e;
    ah_r.s <= ah_nxt.s;
    ah_r.e <= ah_nxt.e;
    bi_r   <= bi_nxt;
    ai_r   <= ai_nxt;
  end

  assign before_o = bh_r;
  assign after_o  = ah_r;
  assign b_idx_o  = bi_r;
  assign a_idx_o  = ai_r;

endmodule

>>> rtl/core/interval_table_editor_top.sv
// Clear and unused codes load the result word directly; read goes through a table read;
// append decides, then shifts and inserts when there is room; searching edits scan first.
// One word is in flight at a time: the next word is accepted the cycle after the result
// loads, and a held result stalls.
// Reset (synchronous, rst_n low): count and video length to zero; table contents
// stay undefined until written.
module interval_table_editor_top import ite_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  ite_in_if.sink      in_ch,
  ite_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_SHIFT  = 3'd3;
  localparam logic [2:0] ST_INSERT = 3'd4;
  localparam logic [2:0] ST_READ   = 3'd5;
  localparam logic [2:0] ST_RDATA  = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [TW-1:0] vlen_r, vlen_nxt;
  logic [2:0]    cmd_r, cmd_nxt;
  logic [TW-1:0] tp_r, tp_nxt, te_r, te_nxt;
  logic [3:0]    idx_r, idx_nxt;
  logic [CW-1:0] i_r, i_nxt, p_r, p_nxt, ins_pos_r, ins_pos_nxt;
  logic          sv_r, sv_nxt, pend_v_r, pend_v_nxt;
  logic [AW-1:0] sidx_r, sidx_nxt, pend_addr_r, pend_addr_nxt;
  logic [TW-1:0] ins_s_r, ins_s_nxt, ins_e_r, ins_e_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  logic          res_ch_r, res_ch_nxt, res_ovf_r, res_ovf_nxt;
  logic [TW-1:0] res_rs_r, res_rs_nxt, res_re_r, res_re_nxt;
  logic          ov_r, ov_nxt;
  logic [CW-1:0] o_count_r, o_count_nxt;
  logic [TW-1:0] o_rs_r, o_rs_nxt, o_re_r, o_re_nxt;
  logic          o_ch_r, o_ch_nxt, o_ovf_r, o_ovf_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  scan_ctl_t     sctl;
  hit_t          bh, ah;
  logic [AW-1:0] b_idx, a_idx;

  logic          d_ins, d_mod, full, ins_ok, mod_ok, in_acc, cfg_wr;
  logic [CW-1:0] d_pos, p_dec;
  logic [TW-1:0] d_s, d_e, d_ms, d_me;
  logic [AW-1:0] d_maddr;

  ite_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ite_scan #(.AW(AW)) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (sctl),
    .idx      (sidx_r),
    .entry    (ram_rdata),
    .t        (tp_r),
    .before_o (bh),
    .after_o  (ah),
    .b_idx_o  (b_idx),
    .a_idx_o  (a_idx)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign sctl.clr    = in_acc;
  assign sctl.en     = sv_r;
  assign full        = (count_r == CW'(TABLE_DEPTH));
  assign p_dec       = p_r - CW'(1);

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : vlen_r;

  // edit decision from the search result
  always_comb begin
    d_ins   = 1'b0;
    d_mod   = 1'b0;
    d_pos   = count_r;
    d_s     = '0;
    d_e     = '0;
    d_maddr = b_idx;
    d_ms    = '0;
    d_me    = '0;
    unique case (cmd_r)
      CMD_APPEND: begin
        d_ins = 1'b1;
        d_s   = tp_r;
        d_e   = te_r;
      end
      CMD_SPLIT: begin
        priority if (count_r == '0) begin
          d_ins = 1'b1;
          d_pos = '0;
          d_e   = vlen_r;
        end else if (!bh.found) begin
          d_ins = ah.found;
          d_pos = '0;
          d_e   = ah.s;
        end else if (!ah.found) begin
          d_ins = 1'b1;
          d_pos = '0;
          d_s   = bh.e;
          d_e   = vlen_r;
        end else if ((bh.s == tp_r) || (bh.e == tp_r)) begin
          d_ins = 1'b0;
        end else if ((tp_r > bh.s) && (tp_r < bh.e)) begin
          d_mod = 1'b1;
          d_ms  = bh.s;
          d_me  = tp_r;
          d_ins = 1'b1;
          d_pos = CW'(b_idx) + CW'(1);
          d_s   = tp_r;
          d_e   = bh.e;
        end else begin
          d_ins = 1'b1;
          d_pos = CW'(b_idx) + CW'(1);
          d_s   = bh.e;
          d_e   = ah.s;
        end
      end
      CMD_TRIM_L: begin
        if (ah.found) begin
          d_mod   = 1'b1;
          d_maddr = a_idx;
          d_ms    = tp_r;
          d_me    = ah.e;
        end else begin
          d_ins = 1'b1;
          d_s   = tp_r;
          d_e   = vlen_r;
        end
      end
      CMD_TRIM_R: begin
        if (bh.found) begin
          d_mod = 1'b1;
          d_ms  = bh.s;
          d_me  = tp_r;
        end else begin
          d_ins = 1'b1;
          d_e   = tp_r;
        end
      end
      default: begin
        d_ins = 1'b0;
      end
    endcase
  end

  assign ins_ok = d_ins && !full;
  assign mod_ok = d_mod && !(d_ins && full);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    vlen_nxt      = cfg_wr ? pwdata : vlen_r;
    cmd_nxt       = cmd_r;
    tp_nxt        = tp_r;
    te_nxt        = te_r;
    idx_nxt       = idx_r;
    i_nxt         = i_r;
    p_nxt         = p_r;
    sv_nxt        = 1'b0;
    sidx_nxt      = sidx_r;
    pend_v_nxt    = 1'b0;
    pend_addr_nxt = pend_addr_r;
    ins_pos_nxt   = ins_pos_r;
    ins_s_nxt     = ins_s_r;
    ins_e_nxt     = ins_e_r;
    rd_ok_nxt     = rd_ok_r;
    res_ch_nxt    = res_ch_r;
    res_ovf_nxt   = res_ovf_r;
    res_rs_nxt    = res_rs_r;
    res_re_nxt    = res_re_r;
    ov_nxt        = ov_r && !out_ch.ready;
    o_count_nxt   = o_count_r;
    o_rs_nxt      = o_rs_r;
    o_re_nxt      = o_re_r;
    o_ch_nxt      = o_ch_r;
    o_ovf_nxt     = o_ovf_r;
    ram_we        = 1'b0;
    ram_waddr     = ins_pos_r[AW-1:0];
    ram_wdata     = {ins_s_r, ins_e_r};
    ram_raddr     = i_r[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt     = in_ch.cmd;
          tp_nxt      = in_ch.time_point;
          te_nxt      = in_ch.time_end;
          idx_nxt     = in_ch.entry_index;
          res_ch_nxt  = 1'b0;
          res_ovf_nxt = 1'b0;
          res_rs_nxt  = '0;
          res_re_nxt  = '0;
          i_nxt       = '0;
          unique case (in_ch.cmd)
            CMD_CLEAR: begin
              count_nxt  = '0;
              res_ch_nxt = 1'b1;
              state_nxt  = ST_DONE;
            end
            CMD_APPEND: state_nxt = ST_DECIDE;
            CMD_SPLIT, CMD_TRIM_L, CMD_TRIM_R: state_nxt = ST_SCAN;
            CMD_READ: state_nxt = ST_READ;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (i_r < count_r) begin
          ram_raddr = i_r[AW-1:0];
          sv_nxt    = 1'b1;
          sidx_nxt  = i_r[AW-1:0];
          i_nxt     = i_r + CW'(1);
        end else begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        ram_we      = mod_ok;
        ram_waddr   = d_maddr;
        ram_wdata   = {d_ms, d_me};
        res_ch_nxt  = ins_ok || mod_ok;
        res_ovf_nxt = d_ins && full;
        ins_pos_nxt = d_pos;
        ins_s_nxt   = d_s;
        ins_e_nxt   = d_e;
        p_nxt       = count_r;
        state_nxt   = ins_ok ? ST_SHIFT : ST_DONE;
      end
      ST_SHIFT: begin
        // write back the entry read last cycle one slot higher
        ram_we    = pend_v_r;
        ram_waddr = pend_addr_r;
        ram_wdata = ram_rdata;
        if (p_r > ins_pos_r) begin
          ram_raddr     = p_dec[AW-1:0];
          pend_v_nxt    = 1'b1;
          pend_addr_nxt = p_r[AW-1:0];
          p_nxt         = p_dec;
        end else begin
          state_nxt = ST_INSERT;
        end
      end
      ST_INSERT: begin
        ram_we    = 1'b1;
        count_nxt = count_r + CW'(1);
        state_nxt = ST_DONE;
      end
      ST_READ: begin
        ram_raddr = AW'(idx_r);
        rd_ok_nxt = (32'(idx_r) < 32'(count_r));
        state_nxt = ST_RDATA;
      end
      ST_RDATA: begin
        if (rd_ok_r) begin
          res_rs_nxt = ram_rdata[EW-1:TW];
          res_re_nxt = ram_rdata[TW-1:0];
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt      = 1'b1;
          o_count_nxt = count_r;
          o_rs_nxt    = res_rs_r;
          o_re_nxt    = res_re_r;
          o_ch_nxt    = res_ch_r;
          o_ovf_nxt   = res_ovf_r;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      vlen_r   <= '0;
      sv_r     <= 1'b0;
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      vlen_r   <= vlen_nxt;
      sv_r     <= sv_nxt;
      pend_v_r <= pend_v_nxt;
      ov_r     <= ov_nxt;
    end
    cmd_r       <= cmd_nxt;
    tp_r        <= tp_nxt;
    te_r        <= te_nxt;
    idx_r       <= idx_nxt;
    i_r         <= i_nxt;
    p_r         <= p_nxt;
    sidx_r      <= sidx_nxt;
    pend_addr_r <= pend_addr_nxt;
    ins_pos_r   <= ins_pos_nxt;
    ins_s_r     <= ins_s_nxt;
    ins_e_r     <= ins_e_nxt;
    rd_ok_r     <= rd_ok_nxt;
    res_ch_r    <= res_ch_nxt;
    res_ovf_r   <= res_ovf_nxt;
    res_rs_r    <= res_rs_nxt;
    res_re_r    <= res_re_nxt;
    o_count_r   <= o_count_nxt;
    o_rs_r      <= o_rs_nxt;
    o_re_r      <= o_re_nxt;
    o_ch_r      <= o_ch_nxt;
    o_ovf_r     <= o_ovf_nxt;
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.entry_count   = o_count_r;
  assign out_ch.read_start    = o_rs_r;
  assign out_ch.read_end      = o_re_r;
  assign out_ch.table_changed = o_ch_r;
  assign out_ch.overflow      = o_ovf_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("ready held while a word is in progress");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.overflow) |->
      (!out_ch.table_changed && (out_ch.entry_count == CW'(TABLE_DEPTH))))
    else $error("overflow flagged on a table that was not full");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r != ST_IDLE))
    else $error("table written while idle");

endmodule
